[rtl/rbw_pkg.sv]
// ----------------------------------------------------------------------------
// rbw_pkg: shared types and constants for the relative bearing pipeline
// widths, angle constants, arctangent table and the per-stage data record
// ----------------------------------------------------------------------------
package rbw_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = 17;
  localparam int ABS_W     = 18;
  localparam int FRAC_W    = 16;
  localparam int XY_W      = 36;
  localparam int Z_W       = 26;
  localparam int ANGLE_W   = 16;
  localparam int REL_W     = 18;
  localparam int TABLE_LEN = 24;
  localparam int TAB_IDX_W = 5;
  localparam int ROUND_SH  = 8;

  localparam logic signed [Z_W-1:0]   HALF_TURN_FINE = Z_W'(5898240);
  localparam logic signed [Z_W-1:0]   ROUND_HALF     = Z_W'(128);
  localparam logic signed [Z_W-1:0]   HALF_TURN_Z    = Z_W'(23040);
  localparam logic signed [REL_W-1:0] HALF_TURN      = REL_W'(23040);
  localparam logic signed [REL_W-1:0] FULL_TURN      = REL_W'(46080);

  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
    logic signed [ANGLE_W-1:0] heading;
    logic                      zero;
  } cordic_t;

  // atan(2^-i) in degrees times 32768, rounded
  function automatic logic signed [Z_W-1:0] atan_fine(input logic [TAB_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = Z_W'(1474560);
      5'd1:    v = Z_W'(870484);
      5'd2:    v = Z_W'(459940);
      5'd3:    v = Z_W'(233473);
      5'd4:    v = Z_W'(117189);
      5'd5:    v = Z_W'(58653);
      5'd6:    v = Z_W'(29333);
      5'd7:    v = Z_W'(14667);
      5'd8:    v = Z_W'(7334);
      5'd9:    v = Z_W'(3667);
      5'd10:   v = Z_W'(1833);
      5'd11:   v = Z_W'(917);
      5'd12:   v = Z_W'(458);
      5'd13:   v = Z_W'(229);
      5'd14:   v = Z_W'(115);
      5'd15:   v = Z_W'(57);
      5'd16:   v = Z_W'(29);
      5'd17:   v = Z_W'(14);
      5'd18:   v = Z_W'(7);
      5'd19:   v = Z_W'(4);
      5'd20:   v = Z_W'(2);
      5'd21:   v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/rbw_prep.sv]
// ----------------------------------------------------------------------------
// rbw_prep: position difference and quadrant fold
// forms target minus observer, folds the left half plane and seeds the angle
// ----------------------------------------------------------------------------
module rbw_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [rbw_pkg::COORD_W-1:0]  observer_x_i,
  input  logic signed [rbw_pkg::COORD_W-1:0]  observer_y_i,
  input  logic signed [rbw_pkg::ANGLE_W-1:0]  observer_heading_i,
  input  logic signed [rbw_pkg::COORD_W-1:0]  target_x_i,
  input  logic signed [rbw_pkg::COORD_W-1:0]  target_y_i,
  output logic                                valid_o,
  output rbw_pkg::cordic_t                    data_o
);

  logic signed [rbw_pkg::DIFF_W-1:0] dx, dy;
  logic signed [rbw_pkg::ABS_W-1:0]  ex, ey, fx, fy;
  rbw_pkg::cordic_t                  data_d, data_q;
  logic                              valid_q;

  always_comb begin
    dx = {target_x_i[rbw_pkg::COORD_W-1], target_x_i}
       - {observer_x_i[rbw_pkg::COORD_W-1], observer_x_i};
    dy = {target_y_i[rbw_pkg::COORD_W-1], target_y_i}
       - {observer_y_i[rbw_pkg::COORD_W-1], observer_y_i};
    ex = {dx[rbw_pkg::DIFF_W-1], dx};
    ey = {dy[rbw_pkg::DIFF_W-1], dy};
    data_d.heading = observer_heading_i;
    data_d.zero    = (dx == '0) && (dy == '0);
    // left half plane: negate and start from +-180 degrees
    if (dx[rbw_pkg::DIFF_W-1]) begin
      fx = -ex;
      fy = -ey;
      data_d.z = dy[rbw_pkg::DIFF_W-1] ? -rbw_pkg::HALF_TURN_FINE : rbw_pkg::HALF_TURN_FINE;
    end else begin
      fx = ex;
      fy = ey;
      data_d.z = '0;
    end
    data_d.x = {{(rbw_pkg::XY_W-rbw_pkg::ABS_W-rbw_pkg::FRAC_W){fx[rbw_pkg::ABS_W-1]}},
                fx, {rbw_pkg::FRAC_W{1'b0}}};
    data_d.y = {{(rbw_pkg::XY_W-rbw_pkg::ABS_W-rbw_pkg::FRAC_W){fy[rbw_pkg::ABS_W-1]}},
                fy, {rbw_pkg::FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/rbw_stage.sv]
// ----------------------------------------------------------------------------
// rbw_stage: one vectoring cordic iteration
// rotates toward the x axis by atan(2^-STAGE_IDX) and registers the result
// ----------------------------------------------------------------------------
module rbw_stage #(
  parameter int STAGE_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  rbw_pkg::cordic_t data_i,
  output logic             valid_o,
  output rbw_pkg::cordic_t data_o
);

  logic signed [rbw_pkg::XY_W-1:0] xs, ys;
  logic signed [rbw_pkg::Z_W-1:0]  step;
  rbw_pkg::cordic_t                data_d, data_q;
  logic                            valid_q;

  always_comb begin
    xs   = data_i.x >>> STAGE_IDX;
    ys   = data_i.y >>> STAGE_IDX;
    step = rbw_pkg::atan_fine(rbw_pkg::TAB_IDX_W'(STAGE_IDX));
    data_d = data_i;
    if (!data_i.y[rbw_pkg::XY_W-1]) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + step;
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/rbw_post.sv]
// ----------------------------------------------------------------------------
// rbw_post: angle rounding, heading subtraction and wrap
// two register stages: round and saturate, then subtract heading and wrap
// ----------------------------------------------------------------------------
module rbw_post (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  rbw_pkg::cordic_t                   data_i,
  output logic                               valid_o,
  output logic signed [rbw_pkg::ANGLE_W-1:0] bearing_o
);

  logic signed [rbw_pkg::Z_W-1:0]     zr, zs;
  logic signed [rbw_pkg::ANGLE_W-1:0] angle_d, angle_q;
  logic signed [rbw_pkg::ANGLE_W-1:0] head_q;
  logic                               valid_a_q;
  logic signed [rbw_pkg::REL_W-1:0]   rel;
  logic signed [rbw_pkg::ANGLE_W-1:0] bearing_d, bearing_q;
  logic                               valid_b_q;

  always_comb begin
    zr = data_i.z + rbw_pkg::ROUND_HALF;
    zs = zr >>> rbw_pkg::ROUND_SH;
    if (data_i.zero) begin
      angle_d = '0;
    end else if (zs > rbw_pkg::HALF_TURN_Z) begin
      angle_d = rbw_pkg::ANGLE_W'(rbw_pkg::HALF_TURN_Z);
    end else if (zs < -rbw_pkg::HALF_TURN_Z) begin
      angle_d = rbw_pkg::ANGLE_W'(-rbw_pkg::HALF_TURN_Z);
    end else begin
      angle_d = zs[rbw_pkg::ANGLE_W-1:0];
    end
  end

  always_comb begin
    rel = {{(rbw_pkg::REL_W-rbw_pkg::ANGLE_W){angle_q[rbw_pkg::ANGLE_W-1]}}, angle_q}
        - {{(rbw_pkg::REL_W-rbw_pkg::ANGLE_W){head_q[rbw_pkg::ANGLE_W-1]}}, head_q};
    // single wrap, at most one of the two fires
    if (rel < -rbw_pkg::HALF_TURN) begin
      rel = rel + rbw_pkg::FULL_TURN;
    end
    if (rel > rbw_pkg::HALF_TURN) begin
      rel = rel - rbw_pkg::FULL_TURN;
    end
    bearing_d = rel[rbw_pkg::ANGLE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q   <= angle_d;
    head_q    <= data_i.heading;
    bearing_q <= bearing_d;
  end

  assign valid_o   = valid_b_q;
  assign bearing_o = bearing_q;

endmodule

[rtl/relative_bearing_wrap.sv]
// ----------------------------------------------------------------------------
// relative_bearing_wrap: bearing to a target relative to the observer heading
// an item taken on start passes the prep register, the cordic stage registers
//   and the post registers before its result shows on done
// throughput: one item per cycle, busy stays low; results cannot be stalled
// reset: clears all valid bits at once, no result is in flight afterwards
// ----------------------------------------------------------------------------
module relative_bearing_wrap #(
  parameter int ANGLE_STAGES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rbw_pkg::COORD_W-1:0]  observer_x_i,
  input  logic signed [rbw_pkg::COORD_W-1:0]  observer_y_i,
  input  logic signed [rbw_pkg::ANGLE_W-1:0]  observer_heading_i,
  input  logic signed [rbw_pkg::COORD_W-1:0]  target_x_i,
  input  logic signed [rbw_pkg::COORD_W-1:0]  target_y_i,
  output logic                                done,
  output logic signed [rbw_pkg::ANGLE_W-1:0]  bearing_o
);

  localparam int NUM_STAGES = (ANGLE_STAGES > rbw_pkg::TABLE_LEN) ?
                              rbw_pkg::TABLE_LEN : ANGLE_STAGES;

  rbw_pkg::cordic_t        pipe [0:NUM_STAGES];
  logic [NUM_STAGES:0]     vld;

  // every stage advances each cycle
  assign busy = 1'b0;

  rbw_prep u_prep (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (start),
    .observer_x_i       (observer_x_i),
    .observer_y_i       (observer_y_i),
    .observer_heading_i (observer_heading_i),
    .target_x_i         (target_x_i),
    .target_y_i         (target_y_i),
    .valid_o            (vld[0]),
    .data_o             (pipe[0])
  );

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    rbw_stage #(
      .STAGE_IDX (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .data_i  (pipe[i]),
      .valid_o (vld[i+1]),
      .data_o  (pipe[i+1])
    );
  end

  rbw_post u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vld[NUM_STAGES]),
    .data_i    (pipe[NUM_STAGES]),
    .valid_o   (done),
    .bearing_o (bearing_o)
  );

endmodule

[rtl/rbw_checker.sv]
// ----------------------------------------------------------------------------
// rbw_checker: port-level checks for relative_bearing_wrap
// result timing against accepted items and output range
// ----------------------------------------------------------------------------
module rbw_checker #(
  parameter int ANGLE_STAGES = 16
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic signed [rbw_pkg::ANGLE_W-1:0] bearing_o
);

  localparam int NUM_STAGES = (ANGLE_STAGES > rbw_pkg::TABLE_LEN) ?
                              rbw_pkg::TABLE_LEN : ANGLE_STAGES;
  localparam int LATENCY    = NUM_STAGES + 3;
  localparam logic signed [rbw_pkg::ANGLE_W-1:0] MAX_BEARING = rbw_pkg::ANGLE_W'(23040);

  // every accepted item produces a matching result on done
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted item produced no result");

  // no result without an item accepted the matching number of cycles earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(start && !busy && rst_ni, LATENCY))
    else $error("result without a matching item");

  // bearing stays wrapped into the half turn range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (bearing_o <= MAX_BEARING) && (bearing_o >= -MAX_BEARING))
    else $error("bearing out of range");

  // the pipeline never refuses an item
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy asserted");

endmodule

bind relative_bearing_wrap rbw_checker #(
  .ANGLE_STAGES (ANGLE_STAGES)
) u_rbw_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .bearing_o (bearing_o)
);

[tb/sv/relative_bearing_wrap_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_bearing_wrap_tb: self-checking bench for the relative bearing pipe
// queries go in through start/busy, every done strobe is checked against a
// bit-exact cordic bearing predictor; directed corner cases, then random mix
// ----------------------------------------------------------------------------
module relative_bearing_wrap_tb;

  localparam int ANGLE_STAGES = 16;
  localparam int PIPE_LAT     = ((ANGLE_STAGES > 24) ? 24 : ANGLE_STAGES) + 3;
  localparam int N_RANDOM     = 550;
  localparam int CALM_TAIL    = 80;
  localparam longint HALF_DEG = 23040;
  localparam longint FULL_DEG = 46080;
  localparam longint HALF_FINE = 5898240;

  typedef struct {
    logic signed [rbw_pkg::COORD_W-1:0] obs_x;
    logic signed [rbw_pkg::COORD_W-1:0] obs_y;
    logic signed [rbw_pkg::ANGLE_W-1:0] obs_hd;
    logic signed [rbw_pkg::COORD_W-1:0] tgt_x;
    logic signed [rbw_pkg::COORD_W-1:0] tgt_y;
  } query_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  logic done;
  logic signed [rbw_pkg::COORD_W-1:0] observer_x_i       = '0;
  logic signed [rbw_pkg::COORD_W-1:0] observer_y_i       = '0;
  logic signed [rbw_pkg::ANGLE_W-1:0] observer_heading_i = '0;
  logic signed [rbw_pkg::COORD_W-1:0] target_x_i         = '0;
  logic signed [rbw_pkg::COORD_W-1:0] target_y_i         = '0;
  logic signed [rbw_pkg::ANGLE_W-1:0] bearing_o;

  query_t query_q[$];
  logic signed [rbw_pkg::ANGLE_W-1:0] bearing_q[$];
  logic signed [rbw_pkg::ANGLE_W-1:0] want_bearing;

  logic took_item = 1'b0;
  int   gap_left  = 0;
  int   n_sent    = 0;
  int   n_results = 0;
  int   n_coinc   = 0;
  int   n_errors  = 0;
  int   n_directed = 0;

  relative_bearing_wrap #(
    .ANGLE_STAGES(ANGLE_STAGES)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .observer_x_i       (observer_x_i),
    .observer_y_i       (observer_y_i),
    .observer_heading_i (observer_heading_i),
    .target_x_i         (target_x_i),
    .target_y_i         (target_y_i),
    .done               (done),
    .bearing_o          (bearing_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // atan(2^-i) in 1/32768 degree
  function automatic longint atan_step(input int i);
    case (i)
      0:  return 1474560;
      1:  return 870484;
      2:  return 459940;
      3:  return 233473;
      4:  return 117189;
      5:  return 58653;
      6:  return 29333;
      7:  return 14667;
      8:  return 7334;
      9:  return 3667;
      10: return 1833;
      11: return 917;
      12: return 458;
      13: return 229;
      14: return 115;
      15: return 57;
      16: return 29;
      17: return 14;
      18: return 7;
      19: return 4;
      20: return 2;
      21: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [rbw_pkg::ANGLE_W-1:0] predict_bearing(
    input logic signed [rbw_pkg::COORD_W-1:0] ox,
    input logic signed [rbw_pkg::COORD_W-1:0] oy,
    input logic signed [rbw_pkg::ANGLE_W-1:0] hd,
    input logic signed [rbw_pkg::COORD_W-1:0] tx,
    input logic signed [rbw_pkg::COORD_W-1:0] ty
  );
    longint dx, dy, x, y, z, xs, ys, ang, rel;
    int     n_stages;
    dx = longint'(tx) - longint'(ox);
    dy = longint'(ty) - longint'(oy);
    n_stages = (ANGLE_STAGES > 24) ? 24 : ANGLE_STAGES;
    z = 0;
    if (dx == 0 && dy == 0) begin
      ang = 0;
    end else begin
      // left half plane: fold over and preload a half turn
      if (dx < 0) begin
        z  = (dy >= 0) ? HALF_FINE : -HALF_FINE;
        dx = -dx;
        dy = -dy;
      end
      x = dx * 65536;
      y = dy * 65536;
      for (int i = 0; i < n_stages; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_step(i);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_step(i);
        end
      end
      ang = (z + 128) >>> 8;
      if (ang > HALF_DEG) ang = HALF_DEG;
      if (ang < -HALF_DEG) ang = -HALF_DEG;
    end
    rel = ang - longint'(hd);
    if (rel < -HALF_DEG) rel = rel + FULL_DEG;
    if (rel > HALF_DEG) rel = rel - FULL_DEG;
    return rel[rbw_pkg::ANGLE_W-1:0];
  endfunction

  task automatic add_query(input int ox, input int oy, input int hd, input int tx, input int ty);
    query_t q;
    q.obs_x  = 16'(ox);
    q.obs_y  = 16'(oy);
    q.obs_hd = 16'(hd);
    q.tgt_x  = 16'(tx);
    q.tgt_y  = 16'(ty);
    query_q.push_back(q);
  endtask

  // driver: present the head of the pending queue, with random idle bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took_item) begin
      // item still waiting to be taken, hold it
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (query_q.size() == 0 ||
                 ((n_sent == n_directed || n_sent == n_directed + 250) &&
                  bearing_q.size() != 0)) begin
      // nothing left, or holding off until the pipe has drained
      start <= 1'b0;
    end else if (query_q.size() > CALM_TAIL && ((n_sent / 60) % 3) != 2 &&
                 $urandom_range(0, 5) == 0) begin
      start    <= 1'b0;
      gap_left <= $urandom_range(0, 7);
    end else begin
      start              <= 1'b1;
      observer_x_i       <= query_q[0].obs_x;
      observer_y_i       <= query_q[0].obs_y;
      observer_heading_i <= query_q[0].obs_hd;
      target_x_i         <= query_q[0].tgt_x;
      target_y_i         <= query_q[0].tgt_y;
    end
  end

  // monitor: check results first, then record the item taken at this edge
  always @(posedge clk_i) begin
    took_item = 1'b0;
    if (rst_ni) begin
      if (done) begin
        if (bearing_q.size() == 0) begin
          $error("bearing: no item pending, actual %0d", bearing_o);
          n_errors++;
        end else begin
          want_bearing = bearing_q.pop_front();
          n_results++;
          if (bearing_o !== want_bearing) begin
            $error("bearing: expected %0d, actual %0d", want_bearing, bearing_o);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        bearing_q.push_back(predict_bearing(observer_x_i, observer_y_i,
                                            observer_heading_i, target_x_i, target_y_i));
        if (observer_x_i == target_x_i && observer_y_i == target_y_i) n_coinc++;
        void'(query_q.pop_front());
        took_item = 1'b1;
        n_sent++;
      end
    end
  end

  initial begin
    int ox, oy, dx, dy, hd;
    // directed corners
    add_query(0, 0, 0, 0, 0);                         // coincident at origin
    add_query(-32768, -32768, 23040, -32768, -32768); // coincident at the corner
    add_query(32767, 32767, -32768, 32767, 32767);
    add_query(0, 0, 0, 100, 0);                       // straight ahead
    add_query(0, 0, 0, -100, 0);                      // directly behind, dy zero
    add_query(0, 0, 0, -100, -1);                     // behind, just below axis
    add_query(0, 0, 0, -100, 1);
    add_query(0, 0, 0, 0, 200);                       // straight up
    add_query(0, 0, 0, 0, -200);
    add_query(-32768, 0, 0, 32767, 0);                // widest differences
    add_query(32767, 0, 0, -32768, 0);
    add_query(0, -32768, 0, 0, 32767);
    add_query(0, 32767, 0, 0, -32768);
    add_query(-32768, -32768, 0, 32767, 32767);
    add_query(32767, 32767, 0, -32768, -32768);
    add_query(32767, -32768, 11520, -32768, -32767);  // just under plus half turn
    add_query(32767, 32767, -23040, -32768, 32767);   // wraps down from above
    add_query(0, 0, 23040, -500, -1);                 // wraps up from below
    add_query(0, 0, -23040, 0, 0);
    add_query(0, 0, 32767, 10, 10);                   // heading past range
    add_query(0, 0, -32768, -10, 10);
    add_query(-1, 1, 23040, -2, 0);
    add_query(5, -5, -1, 6, -5);
    n_directed = query_q.size();

    for (int k = 0; k < N_RANDOM; k++) begin
      if ($urandom_range(0, 3) == 0) hd = int'(16'($urandom)) - ((($urandom & 32'h8000) != 0) ? 0 : 0);
      else hd = $urandom_range(0, 46080) - 23040;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          add_query($urandom, $urandom, hd, $urandom, $urandom);
        end
        6, 7: begin
          // short range target
          ox = $urandom_range(0, 60000) - 30000;
          oy = $urandom_range(0, 60000) - 30000;
          dx = $urandom_range(0, 1024) - 512;
          dy = $urandom_range(0, 1024) - 512;
          add_query(ox, oy, hd, ox + dx, oy + dy);
        end
        8: begin
          ox = $urandom;
          oy = $urandom;
          add_query(ox, oy, hd, ox, oy);
        end
        default: begin
          // on an axis
          ox = $urandom_range(0, 60000) - 30000;
          oy = $urandom_range(0, 60000) - 30000;
          dx = $urandom_range(0, 2700) - 1350;
          if ($urandom_range(0, 1) == 0) add_query(ox, oy, hd, ox + dx, oy);
          else add_query(ox, oy, hd, ox, oy + dx);
        end
      endcase
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    wait (query_q.size() == 0 && bearing_q.size() == 0);
    repeat (2 * PIPE_LAT + 10) @(posedge clk_i);
    $display("run covered %0d queries (%0d coincident), %0d bearings checked",
             n_sent, n_coinc, n_results);
    if (n_errors == 0 && bearing_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout: %0d bearings still pending", bearing_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
